>>> rtl/core/kuz_pkg.sv
// Kuznyechik shared package: word types, S-boxes, GF(2^8) helpers, L transform.
// No dependencies.
package kuz_pkg;

  typedef struct packed {
    logic        op;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_C,
    ST_KEY_F,
    ST_KEY_WR,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD_KEY,
    DP_CONST,
    DP_FEISTEL,
    DP_LOAD_BLOCK,
    DP_ROUND
  } dp_op_t;

  typedef struct packed {
    dp_op_t      op;
    logic [4:0]  iter;
    logic [3:0]  round;
    logic        last;
  } dp_cmd_t;

  localparam logic [1:0] REG_KEY_FIRST_LOW   = 2'd0;
  localparam logic [1:0] REG_KEY_FIRST_HIGH  = 2'd1;
  localparam logic [1:0] REG_KEY_SECOND_LOW  = 2'd2;
  localparam logic [1:0] REG_KEY_SECOND_HIGH = 2'd3;
  localparam int unsigned NUM_REGS = 4;
  localparam int unsigned NUM_ROUNDS = 10;
  localparam int unsigned NUM_ITERS = 32;
  localparam logic [7:0] GF_POLY = 8'hC3;

  localparam logic [7:0] SBOX_FWD [256] = '{
    8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
    8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
    8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
    8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
    8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
    8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
    8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
    8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
    8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
    8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
    8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
    8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
    8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
    8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
    8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
    8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
  };

  localparam logic [7:0] SBOX_INV [256] = '{
    8'hA5,8'h2D,8'h32,8'h8F,8'h0E,8'h30,8'h38,8'hC0,8'h54,8'hE6,8'h9E,8'h39,8'h55,8'h7E,8'h52,8'h91,
    8'h64,8'h03,8'h57,8'h5A,8'h1C,8'h60,8'h07,8'h18,8'h21,8'h72,8'hA8,8'hD1,8'h29,8'hC6,8'hA4,8'h3F,
    8'hE0,8'h27,8'h8D,8'h0C,8'h82,8'hEA,8'hAE,8'hB4,8'h9A,8'h63,8'h49,8'hE5,8'h42,8'hE4,8'h15,8'hB7,
    8'hC8,8'h06,8'h70,8'h9D,8'h41,8'h75,8'h19,8'hC9,8'hAA,8'hFC,8'h4D,8'hBF,8'h2A,8'h73,8'h84,8'hD5,
    8'hC3,8'hAF,8'h2B,8'h86,8'hA7,8'hB1,8'hB2,8'h5B,8'h46,8'hD3,8'h9F,8'hFD,8'hD4,8'h0F,8'h9C,8'h2F,
    8'h9B,8'h43,8'hEF,8'hD9,8'h79,8'hB6,8'h53,8'h7F,8'hC1,8'hF0,8'h23,8'hE7,8'h25,8'h5E,8'hB5,8'h1E,
    8'hA2,8'hDF,8'hA6,8'hFE,8'hAC,8'h22,8'hF9,8'hE2,8'h4A,8'hBC,8'h35,8'hCA,8'hEE,8'h78,8'h05,8'h6B,
    8'h51,8'hE1,8'h59,8'hA3,8'hF2,8'h71,8'h56,8'h11,8'h6A,8'h89,8'h94,8'h65,8'h8C,8'hBB,8'h77,8'h3C,
    8'h7B,8'h28,8'hAB,8'hD2,8'h31,8'hDE,8'hC4,8'h5F,8'hCC,8'hCF,8'h76,8'h2C,8'hB8,8'hD8,8'h2E,8'h36,
    8'hDB,8'h69,8'hB3,8'h14,8'h95,8'hBE,8'h62,8'hA1,8'h3B,8'h16,8'h66,8'hE9,8'h5C,8'h6C,8'h6D,8'hAD,
    8'h37,8'h61,8'h4B,8'hB9,8'hE3,8'hBA,8'hF1,8'hA0,8'h85,8'h83,8'hDA,8'h47,8'hC5,8'hB0,8'h33,8'hFA,
    8'h96,8'h6F,8'h6E,8'hC2,8'hF6,8'h50,8'hFF,8'h5D,8'hA9,8'h8E,8'h17,8'h1B,8'h97,8'h7D,8'hEC,8'h58,
    8'hF7,8'h1F,8'hFB,8'h7C,8'h09,8'h0D,8'h7A,8'h67,8'h45,8'h87,8'hDC,8'hE8,8'h4F,8'h1D,8'h4E,8'h04,
    8'hEB,8'hF8,8'hF3,8'h3E,8'h3D,8'hBD,8'h8A,8'h88,8'hDD,8'hCD,8'h0B,8'h13,8'h98,8'h02,8'h93,8'h80,
    8'h90,8'hD0,8'h24,8'h34,8'hCB,8'hED,8'hF4,8'hCE,8'h99,8'h10,8'h44,8'h40,8'h92,8'h3A,8'h01,8'h26,
    8'h12,8'h1A,8'h48,8'h68,8'hF5,8'h81,8'h8B,8'hC7,8'hD6,8'h20,8'h0A,8'h08,8'h00,8'h4C,8'hD7,8'h74
  };

  localparam logic [7:0] LIN_COEF [16] = '{
    8'd1, 8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1,
    8'd251, 8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148
  };

  // Constant-coefficient GF(2^8) multiply; folds to XOR logic.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] x;
    c = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) c = c ^ x;
      x = x[7] ? ({x[6:0], 1'b0} ^ GF_POLY) : {x[6:0], 1'b0};
    end
    return c;
  endfunction

  // One pass of the byte shift register, forward direction.
  function automatic logic [127:0] lin_step_fwd(input logic [127:0] s);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 16; i++) acc = acc ^ gf_mul(s[8*i +: 8], LIN_COEF[i]);
    return {acc, s[127:8]};
  endfunction

  function automatic logic [127:0] lin_step_inv(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] acc;
    t = {s[119:0], 8'h00};
    acc = s[127:120];
    for (int i = 1; i < 16; i++) acc = acc ^ gf_mul(t[8*i +: 8], LIN_COEF[i]);
    return {t[127:8], acc};
  endfunction

  // Full L as an unrolled matrix; each output byte is a fixed XOR of input bits.
  function automatic logic [127:0] lin_fwd(input logic [127:0] s);
    logic [127:0] t;
    t = s;
    for (int r = 0; r < 16; r++) t = lin_step_fwd(t);
    return t;
  endfunction

  function automatic logic [127:0] lin_inv(input logic [127:0] s);
    logic [127:0] t;
    t = s;
    for (int r = 0; r < 16; r++) t = lin_step_inv(t);
    return t;
  endfunction

  function automatic logic [127:0] sub_fwd(input logic [127:0] s);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) t[8*i +: 8] = SBOX_FWD[s[8*i +: 8]];
    return t;
  endfunction

  function automatic logic [127:0] sub_inv(input logic [127:0] s);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) t[8*i +: 8] = SBOX_INV[s[8*i +: 8]];
    return t;
  endfunction

endpackage

>>> rtl/core/kuz_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module kuz_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/kuz_ctrl.sv
// Kuznyechik sequencer: key schedule and round control.
// Depends on kuz_pkg.
module kuz_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              cfg_touch,
  output logic              busy,
  output logic              done,
  output kuz_pkg::dp_cmd_t  cmd
);
  import kuz_pkg::*;

  state_t     state, state_next;
  logic       keys_ready;
  logic [4:0] iter;
  logic [3:0] round;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = keys_ready ? ST_ROUND : ST_KEY_C;
      ST_KEY_C:  state_next = ST_KEY_F;
      ST_KEY_F:  state_next = (iter[2:0] == 3'd7) ? ST_KEY_WR : ST_KEY_C;
      ST_KEY_WR: state_next = (iter == 5'd0) ? ST_ROUND : ST_KEY_C;
      ST_ROUND:  state_next = (round == 4'(NUM_ROUNDS - 1)) ? ST_DONE : ST_ROUND;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.iter = iter;
    cmd.round = round;
    cmd.last = (round == 4'(NUM_ROUNDS - 1));
    case (state)
      ST_IDLE:   cmd.op = start ? (keys_ready ? DP_LOAD_BLOCK : DP_LOAD_KEY) : DP_NOP;
      ST_KEY_C:  cmd.op = DP_CONST;
      ST_KEY_F:  cmd.op = DP_FEISTEL;
      ST_KEY_WR: cmd.op = DP_NOP;
      ST_ROUND:  cmd.op = DP_ROUND;
      ST_DONE:   cmd.op = DP_NOP;
      default:   cmd.op = DP_NOP;
    endcase
    busy = (state != ST_IDLE);
    done = (state == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      keys_ready <= 1'b0;
      iter <= '0;
      round <= '0;
    end else begin
      state <= state_next;
      if (cfg_touch) keys_ready <= 1'b0;
      case (state)
        ST_IDLE: begin
          iter <= '0;
          round <= '0;
        end
        ST_KEY_F:  iter <= iter + 5'd1;
        ST_KEY_WR: if (iter == 5'd0) keys_ready <= 1'b1;
        ST_ROUND:  round <= round + 4'd1;
        default:   ;
      endcase
    end
  end
endmodule

>>> rtl/core/kuz_dp.sv
// Kuznyechik datapath: state register, one-round S+L unit, key-schedule ladder.
// Depends on kuz_pkg and kuz_ram.
module kuz_dp (
  input  logic              clk,
  input  kuz_pkg::dp_cmd_t  cmd,
  input  kuz_pkg::in_word_t in_word,
  input  logic [127:0]      key_first,
  input  logic [127:0]      key_second,
  output kuz_pkg::out_word_t out_word
);
  import kuz_pkg::*;

  logic [127:0] st;
  logic [127:0] k1, k2, cst;
  logic [127:0] rk;
  logic         dec;
  logic         ram_we;
  logic [3:0]   ram_waddr, ram_raddr;
  logic [127:0] ram_wdata;
  logic [127:0] f_out;
  logic [127:0] enc_r, dec_r;
  logic         wr_pair;
  logic [4:0]   iter_prev;

  kuz_ram #(.WIDTH(128), .DEPTH(NUM_ROUNDS)) u_rk (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rk)
  );

  assign f_out = lin_fwd(sub_fwd(k1 ^ cst)) ^ k2;
  assign iter_prev = cmd.iter - 5'd1;

  // Write K1 at load, K2 at the first constant; after each eight iterations store
  // the ladder pair: odd key (old K1) on the eighth Feistel step, even key next.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = k1;
    if (wr_pair) begin
      ram_we = 1'b1;
      ram_waddr = 4'd2 + {1'b0, iter_prev[4:3], 1'b0};
      ram_wdata = k1;
    end else if (cmd.op == DP_FEISTEL && cmd.iter[2:0] == 3'd7) begin
      ram_we = 1'b1;
      ram_waddr = 4'd3 + {1'b0, cmd.iter[4:3], 1'b0};
      ram_wdata = k1;
    end else if (cmd.op == DP_LOAD_KEY) begin
      ram_we = 1'b1;
      ram_waddr = 4'd0;
      ram_wdata = key_first;
    end else if (cmd.op == DP_CONST && cmd.iter == 5'd0) begin
      ram_we = 1'b1;
      ram_waddr = 4'd1;
      ram_wdata = k2;
    end
  end

  // Round key address: encrypt counts up, decrypt down; read runs one ahead.
  always_comb begin
    if (cmd.op == DP_LOAD_BLOCK || cmd.op == DP_LOAD_KEY)
      ram_raddr = in_word.op ? 4'd9 : 4'd0;
    else if (cmd.op == DP_ROUND)
      ram_raddr = dec ? 4'(4'd8 - cmd.round) : 4'(cmd.round + 4'd1);
    else
      ram_raddr = dec ? 4'd9 : 4'd0;
  end

  assign enc_r = lin_fwd(sub_fwd(st ^ rk));
  assign dec_r = sub_inv(lin_inv(st ^ rk));

  always_ff @(posedge clk) begin
    wr_pair <= (cmd.op == DP_FEISTEL) && (cmd.iter[2:0] == 3'd7);
    case (cmd.op)
      DP_LOAD_KEY: begin
        k1 <= key_first;
        k2 <= key_second;
        st <= {in_word.block_high, in_word.block_low};
        dec <= in_word.op;
      end
      DP_CONST: cst <= lin_fwd({120'd0, {3'd0, cmd.iter} + 8'd1});
      DP_FEISTEL: begin
        k1 <= f_out;
        k2 <= k1;
      end
      DP_LOAD_BLOCK: begin
        st <= {in_word.block_high, in_word.block_low};
        dec <= in_word.op;
      end
      DP_ROUND: begin
        if (cmd.last) st <= st ^ rk;
        else st <= dec ? dec_r : enc_r;
      end
      default: ;
    endcase
  end

  assign out_word.result_low = st[63:0];
  assign out_word.result_high = st[127:64];
endmodule

>>> rtl/core/kuznyechik_block_cipher_top.sv
// Kuznyechik block cipher top level: config registers, sequencer and datapath.
// Depends on kuz_pkg, kuz_ctrl, kuz_dp, kuz_ram.
// Usage: write the four 64-bit key registers (index 0..3) while idle, then raise
// start with op and the block. The first block after reset or any key write
// first runs the key schedule: 32 Feistel iterations, each a constant step and
// a Feistel step, with a store step after every eight. A block then runs 10
// rounds (one round per cycle through a single S-box layer and a flattened L
// matrix, the last being the final key add); done strobes in the cycle after
// the last round, and the block is idle again in the cycle after that, taking
// no new block until then. Result appears with done for one cycle; the receiver
// cannot stall it. Hold start off while busy.
module kuznyechik_block_cipher_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  kuz_pkg::in_word_t  in_word,
  output logic               busy,
  output logic               done,
  output kuz_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import kuz_pkg::*;

  logic [63:0] key_regs [NUM_REGS];
  dp_cmd_t     cmd;

  // Hold the key halves; any write invalidates the round keys.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) key_regs[i] <= '0;
    end else if (cfg_we) begin
      key_regs[cfg_index] <= cfg_data;
    end
  end

  kuz_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cfg_touch(cfg_we),
    .busy(busy), .done(done), .cmd(cmd)
  );

  kuz_dp u_dp (
    .clk(clk), .cmd(cmd), .in_word(in_word),
    .key_first({key_regs[REG_KEY_FIRST_HIGH], key_regs[REG_KEY_FIRST_LOW]}),
    .key_second({key_regs[REG_KEY_SECOND_HIGH], key_regs[REG_KEY_SECOND_LOW]}),
    .out_word(out_word)
  );

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done without busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted start did not go busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
`endif
endmodule

>>> dv/tb.sv
// Self-checking testbench for kuznyechik_block_cipher_top: encrypt/decrypt blocks under
// several 256-bit keys, checked against an in-bench cipher model.
// Depends on kuz_pkg (word types, register indexes) and the RTL top level.

class cipher_scoreboard;
  byte unsigned fwd_box [256];
  byte unsigned inv_box [256];
  byte unsigned coef [16];
  bit [63:0] key_regs [4];
  bit [127:0] round_keys [10];
  bit keys_valid;
  kuz_pkg::out_word_t pending_blocks [$];
  int errors;

  function void load_tables(input logic [7:0] f [256], input logic [7:0] v [256],
                            input logic [7:0] c [16]);
    for (int i = 0; i < 256; i++) begin
      fwd_box[i] = f[i];
      inv_box[i] = v[i];
    end
    for (int i = 0; i < 16; i++) coef[i] = c[i];
    errors = 0;
    keys_valid = 0;
    for (int i = 0; i < 4; i++) key_regs[i] = '0;
  endfunction

  function byte unsigned gmul(input byte unsigned a, input byte unsigned b);
    byte unsigned p;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = a[7] ? ((a << 1) ^ 8'hC3) : (a << 1);
      b = b >> 1;
    end
    return p;
  endfunction

  function bit [127:0] mix_fwd(input bit [127:0] s);
    byte unsigned acc;
    for (int r = 0; r < 16; r++) begin
      acc = 0;
      for (int i = 0; i < 16; i++) acc ^= gmul(s[8*i +: 8], coef[i]);
      s = {acc, s[127:8]};
    end
    return s;
  endfunction

  function bit [127:0] mix_inv(input bit [127:0] s);
    byte unsigned acc;
    for (int r = 0; r < 16; r++) begin
      acc = s[127:120];
      s = {s[119:0], 8'h00};
      for (int i = 1; i < 16; i++) acc ^= gmul(s[8*i +: 8], coef[i]);
      s[7:0] = acc;
    end
    return s;
  endfunction

  function bit [127:0] subst(input bit [127:0] s, input bit inverse);
    for (int i = 0; i < 16; i++)
      s[8*i +: 8] = inverse ? inv_box[s[8*i +: 8]] : fwd_box[s[8*i +: 8]];
    return s;
  endfunction

  function void write_key(input int idx, input bit [63:0] val);
    key_regs[idx] = val;
    keys_valid = 0;
  endfunction

  function void expand_schedule();
    bit [127:0] k1, k2, c, t;
    k1 = {key_regs[1], key_regs[0]};
    k2 = {key_regs[3], key_regs[2]};
    round_keys[0] = k1;
    round_keys[1] = k2;
    for (int j = 0; j < 32; j++) begin
      c = '0;
      c[7:0] = 8'(j + 1);
      c = mix_fwd(c);
      t = mix_fwd(subst(k1 ^ c, 1'b0)) ^ k2;
      k2 = k1;
      k1 = t;
      if (j % 8 == 7) begin
        round_keys[2 + 2*(j/8)] = k1;
        round_keys[3 + 2*(j/8)] = k2;
      end
    end
    keys_valid = 1;
  endfunction

  // Note an accepted block and queue its ciphertext or plaintext.
  function void note_block(input kuz_pkg::in_word_t w);
    bit [127:0] s;
    kuz_pkg::out_word_t o;
    if (!keys_valid) expand_schedule();
    s = {w.block_high, w.block_low};
    if (!w.op) begin
      for (int r = 0; r < 9; r++) s = mix_fwd(subst(s ^ round_keys[r], 1'b0));
      s ^= round_keys[9];
    end else begin
      s ^= round_keys[9];
      for (int r = 8; r >= 0; r--) s = subst(mix_inv(s), 1'b1) ^ round_keys[r];
    end
    o.result_high = s[127:64];
    o.result_low = s[63:0];
    pending_blocks.push_back(o);
  endfunction

  function void check_block(input kuz_pkg::out_word_t got);
    kuz_pkg::out_word_t want;
    if (pending_blocks.size() == 0) begin
      $error("unexpected result word %h", got);
      errors++;
      return;
    end
    want = pending_blocks.pop_front();
    if (got.result_low !== want.result_low) begin
      $error("result_low expected %h actual %h", want.result_low, got.result_low);
      errors++;
    end
    if (got.result_high !== want.result_high) begin
      $error("result_high expected %h actual %h", want.result_high, got.result_high);
      errors++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kuz_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  in_word_t in_word = '0;
  logic busy, done;
  out_word_t out_word;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  cipher_scoreboard sb;
  int idle_cycles = 0;

  kuznyechik_block_cipher_top u_top (
    .clk, .rst, .start, .in_word, .busy, .done, .out_word,
    .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Check every result word on the edge that ends its strobe cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_block(out_word);
  end

  // Watchdog: count cycles with no word moving in either direction.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[kuznyechik_block_cipher_top] ERROR");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Write one key register; the block must be idle.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_key(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Write all four key registers back to back, then drop the write enable.
  task automatic load_key(input logic [63:0] k0, k1, k2, k3);
    logic [63:0] vals [4];
    logic [1:0] idxs [4];
    vals = '{k0, k1, k2, k3};
    idxs = '{REG_KEY_FIRST_LOW, REG_KEY_FIRST_HIGH, REG_KEY_SECOND_LOW,
             REG_KEY_SECOND_HIGH};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_key(idxs[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 0;
  endtask

  // Present one word after an optional random gap and hold it until accepted.
  task automatic send_block(input logic op, input logic [63:0] lo, hi, input bit gaps);
    in_word_t w;
    int gap;
    gap = gaps ? $urandom_range(0, 4) : 0;
    repeat (gap + 1) @(negedge clk);
    w.op = op;
    w.block_low = lo;
    w.block_high = hi;
    in_word <= w;
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_block(w);
    @(negedge clk);
    start <= 0;
  endtask

  // Let every queued result drain, plus margin for the done cycle.
  task automatic drain();
    while (sb.pending_blocks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  // Send blocks with a random operation, random gaps and fixed, masked or random data.
  task automatic random_phase(input int count);
    logic [63:0] lo, hi;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 3))
        0: begin lo = '0; hi = '1; end
        1: begin lo = rand64() & {8{8'h0F}}; hi = rand64() | {8{8'hF0}}; end
        default: begin lo = rand64(); hi = rand64(); end
      endcase
      send_block($urandom_range(0, 1), lo, hi, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    sb = new();
    sb.load_tables(SBOX_FWD, SBOX_INV, LIN_COEF);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Block before any key write: schedule from all-zero key.
    send_block(1'b0, '0, '0, 0);
    send_block(1'b1, '0, '0, 0);
    drain();

    // Key from the standard test vector words, then field extremes and both operations.
    load_key(64'h0011223344556677 ^ 64'h0, 64'h8899aabbccddeeff,
             64'hfedcba9876543210, 64'h0123456789abcdef);
    send_block(1'b0, 64'h1122334455667700, 64'hffeeddccbbaa9988, 0);
    send_block(1'b1, 64'h1122334455667700, 64'hffeeddccbbaa9988, 0);
    send_block(1'b0, '1, '1, 0);
    send_block(1'b1, '1, '1, 0);
    send_block(1'b0, '0, '1, 1);
    send_block(1'b1, '1, '0, 1);
    send_block(1'b0, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 0);
    drain();

    // All-ones key; a single register rewrite must re-run the schedule.
    load_key('1, '1, '1, '1);
    send_block(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210, 0);
    send_block(1'b1, '0, '0, 0);
    drain();
    write_reg(REG_KEY_SECOND_HIGH, 64'h8000000000000001);
    send_block(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210, 0);
    drain();

    // Random keys with random traffic.
    for (int p = 0; p < 6; p++) begin
      load_key(rand64(), rand64(), rand64(), rand64());
      random_phase(95);
      drain();
    end
    load_key('0, '0, '0, '0);
    random_phase(15);
    drain();

    if (sb.errors == 0 && sb.pending_blocks.size() == 0) begin
      $display("[kuznyechik_block_cipher_top] OK");
    end else begin
      $display("[kuznyechik_block_cipher_top] ERROR");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/core/kuz_pkg.sv
rtl/core/kuz_ram.sv
rtl/core/kuz_ctrl.sv
rtl/core/kuz_dp.sv
rtl/core/kuznyechik_block_cipher_top.sv
dv/tb.sv
